### sv/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg
// shared types and constants for the json string unescaper
// ----------------------------------------------------------------------------
`default_nettype none

package jsu_pkg;

  typedef enum logic [2:0] {
    PH_OPEN,
    PH_BODY,
    PH_ESC,
    PH_HEX1,
    PH_WANT_BS,
    PH_WANT_U,
    PH_HEX2
  } phase_t;

  typedef enum logic [1:0] {
    JOB_RAW,
    JOB_CP,
    JOB_MARK
  } job_kind_t;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_LONE_LOW  = 2'd1,
    ERR_NO_LOW    = 2'd2
  } err_t;

  typedef struct packed {
    job_kind_t   kind;
    logic [20:0] cp;
    err_t        err;
  } job_t;

  localparam int          FIFO_DEPTH = 4;
  localparam int          FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam logic [15:0] HIGH_FIRST = 16'hD800;
  localparam logic [15:0] HIGH_LAST  = 16'hDBFF;
  localparam logic [15:0] LOW_FIRST  = 16'hDC00;
  localparam logic [15:0] LOW_LAST   = 16'hDFFF;
  localparam logic [20:0] SUPP_BASE  = 21'h10000;
  localparam logic [20:0] LIMIT_1B   = 21'h00080;
  localparam logic [20:0] LIMIT_2B   = 21'h00800;
  localparam logic [20:0] LIMIT_3B   = 21'h10000;

  localparam logic [7:0]  CH_BSLASH  = 8'h5C;
  localparam logic [7:0]  CH_QUOTE   = 8'h22;
  localparam logic [7:0]  CH_SLASH   = 8'h2F;
  localparam logic [7:0]  CH_B       = 8'h62;
  localparam logic [7:0]  CH_F       = 8'h66;
  localparam logic [7:0]  CH_N       = 8'h6E;
  localparam logic [7:0]  CH_R       = 8'h72;
  localparam logic [7:0]  CH_T       = 8'h74;
  localparam logic [7:0]  CH_U       = 8'h75;
  localparam logic [7:0]  CH_0       = 8'h30;
  localparam logic [7:0]  CH_9       = 8'h39;
  localparam logic [7:0]  CH_A_LO    = 8'h61;
  localparam logic [7:0]  CH_F_LO    = 8'h66;

endpackage

`default_nettype wire

### sv/jsu_front.sv
// ----------------------------------------------------------------------------
// jsu_front
// parses the token bytes and issues one job per byte that yields results
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          accept,
  input  wire logic [7:0]    text_byte,
  input  wire logic          last_byte,
  output jsu_pkg::job_t      job,
  output logic               job_push
);
  import jsu_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [15:0] acc_r, acc_nxt;
  logic [9:0]  held_r, held_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        disc_r, disc_nxt;

  logic [3:0]  nib;
  logic [15:0] unit;
  logic        unit_done;
  logic        is_low;
  logic        is_high;

  always_comb begin
    if (text_byte >= CH_0 && text_byte <= CH_9) begin
      nib = text_byte[3:0];
    end else begin
      nib = text_byte[3:0] + 4'd9;
    end
  end

  assign unit      = {acc_r[11:0], nib};
  assign unit_done = (cnt_r == 2'd3);
  assign is_low    = (unit >= LOW_FIRST) && (unit <= LOW_LAST);
  assign is_high   = (unit >= HIGH_FIRST) && (unit <= HIGH_LAST);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_OPEN;
      acc_r   <= '0;
      held_r  <= '0;
      cnt_r   <= '0;
      disc_r  <= 1'b0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      held_r  <= held_nxt;
      cnt_r   <= cnt_nxt;
      disc_r  <= disc_nxt;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    held_nxt  = held_r;
    cnt_nxt   = cnt_r;
    disc_nxt  = disc_r;
    job       = '{kind: JOB_RAW, cp: {13'd0, text_byte}, err: ERR_NONE};
    job_push  = 1'b0;

    if (disc_r) begin
      if (last_byte) begin
        disc_nxt = 1'b0;
      end
    end else if (phase_r == PH_OPEN) begin
      if (last_byte) begin
        job      = '{kind: JOB_MARK, cp: '0, err: ERR_NONE};
        job_push = 1'b1;
      end else begin
        phase_nxt = PH_BODY;
      end
    end else if (last_byte) begin
      job_push = 1'b1;
      if (phase_r == PH_WANT_BS || phase_r == PH_WANT_U || phase_r == PH_HEX2) begin
        job = '{kind: JOB_MARK, cp: '0, err: ERR_NO_LOW};
      end else begin
        job = '{kind: JOB_MARK, cp: '0, err: ERR_NONE};
      end
      phase_nxt = PH_OPEN;
      acc_nxt   = '0;
      held_nxt  = '0;
      cnt_nxt   = '0;
    end else begin
      case (phase_r)
        PH_BODY: begin
          if (text_byte == CH_BSLASH) begin
            phase_nxt = PH_ESC;
          end else begin
            job_push = 1'b1;
          end
        end
        PH_ESC: begin
          phase_nxt = PH_BODY;
          job_push  = 1'b1;
          case (text_byte)
            CH_QUOTE:  job.cp = {13'd0, CH_QUOTE};
            CH_BSLASH: job.cp = {13'd0, CH_BSLASH};
            CH_SLASH:  job.cp = {13'd0, CH_SLASH};
            CH_B:      job.cp = 21'h08;
            CH_F:      job.cp = 21'h0C;
            CH_N:      job.cp = 21'h0A;
            CH_R:      job.cp = 21'h0D;
            CH_T:      job.cp = 21'h09;
            default: begin
              job_push  = 1'b0;
              phase_nxt = PH_HEX1;
              acc_nxt   = '0;
              cnt_nxt   = '0;
            end
          endcase
        end
        PH_HEX1: begin
          acc_nxt = unit;
          cnt_nxt = cnt_r + 2'd1;
          if (unit_done) begin
            acc_nxt = '0;
            cnt_nxt = '0;
            if (is_low) begin
              job       = '{kind: JOB_MARK, cp: '0, err: ERR_LONE_LOW};
              job_push  = 1'b1;
              phase_nxt = PH_OPEN;
              held_nxt  = '0;
              disc_nxt  = 1'b1;
            end else if (is_high) begin
              held_nxt  = unit[9:0];
              phase_nxt = PH_WANT_BS;
            end else begin
              job       = '{kind: JOB_CP, cp: {5'd0, unit}, err: ERR_NONE};
              job_push  = 1'b1;
              phase_nxt = PH_BODY;
            end
          end
        end
        PH_WANT_BS, PH_WANT_U: begin
          if (phase_r == PH_WANT_BS && text_byte == CH_BSLASH) begin
            phase_nxt = PH_WANT_U;
          end else if (phase_r == PH_WANT_U && text_byte == CH_U) begin
            phase_nxt = PH_HEX2;
            acc_nxt   = '0;
            cnt_nxt   = '0;
          end else begin
            job       = '{kind: JOB_MARK, cp: '0, err: ERR_NO_LOW};
            job_push  = 1'b1;
            phase_nxt = PH_OPEN;
            acc_nxt   = '0;
            held_nxt  = '0;
            cnt_nxt   = '0;
            disc_nxt  = 1'b1;
          end
        end
        PH_HEX2: begin
          acc_nxt = unit;
          cnt_nxt = cnt_r + 2'd1;
          if (unit_done) begin
            acc_nxt  = '0;
            cnt_nxt  = '0;
            held_nxt = '0;
            job_push = 1'b1;
            if (is_low) begin
              job       = '{kind: JOB_CP, cp: SUPP_BASE + {1'b0, held_r, unit[9:0]},
                            err: ERR_NONE};
              phase_nxt = PH_BODY;
            end else begin
              job       = '{kind: JOB_MARK, cp: '0, err: ERR_NO_LOW};
              phase_nxt = PH_OPEN;
              disc_nxt  = 1'b1;
            end
          end
        end
        default: begin
          phase_nxt = PH_OPEN;
          acc_nxt   = '0;
          held_nxt  = '0;
          cnt_nxt   = '0;
          disc_nxt  = 1'b0;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### sv/jsu_fifo.sv
// ----------------------------------------------------------------------------
// jsu_fifo
// short job queue between the parser and the byte sequencer
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_fifo (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire jsu_pkg::job_t  push_job,
  input  wire logic           pop,
  output jsu_pkg::job_t       head_job,
  output logic                empty,
  output logic                full
);
  import jsu_pkg::*;

  job_t               mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r;
  logic [FIFO_AW-1:0] rd_ptr_r;
  logic [FIFO_AW:0]   count_r;

  assign empty    = (count_r == '0);
  assign full     = (count_r == (FIFO_AW+1)'(FIFO_DEPTH));
  assign head_job = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### sv/jsu_back.sv
// ----------------------------------------------------------------------------
// jsu_back
// turns queued jobs into result beats, one utf-8 byte per cycle while out_stall is low
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire jsu_pkg::job_t head_job,
  input  wire logic          empty,
  output logic               pop,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic [7:0]         out_byte,
  output logic               out_byte_valid,
  output logic               out_end_of_run,
  output logic               out_end_of_string,
  output logic [1:0]         out_error_code
);
  import jsu_pkg::*;

  logic [1:0] idx_r, idx_nxt;
  logic       valid_r, valid_nxt;
  logic [7:0] byte_r;
  logic       bval_r;
  logic       eor_r;
  logic       eos_r;
  logic [1:0] err_r;

  logic [7:0] enc [4];
  logic [1:0] last_idx;
  logic       adv;
  logic       emit;
  logic       at_last;
  logic [20:0] cp;

  assign cp = head_job.cp;

  always_comb begin
    enc[0]   = cp[7:0];
    enc[1]   = '0;
    enc[2]   = '0;
    enc[3]   = '0;
    last_idx = 2'd0;
    if (head_job.kind == JOB_MARK) begin
      enc[0] = '0;
    end else if (head_job.kind == JOB_CP) begin
      if (cp < LIMIT_1B) begin
        enc[0] = cp[7:0];
      end else if (cp < LIMIT_2B) begin
        enc[0]   = {3'b110, cp[10:6]};
        enc[1]   = {2'b10, cp[5:0]};
        last_idx = 2'd1;
      end else if (cp < LIMIT_3B) begin
        enc[0]   = {4'b1110, cp[15:12]};
        enc[1]   = {2'b10, cp[11:6]};
        enc[2]   = {2'b10, cp[5:0]};
        last_idx = 2'd2;
      end else begin
        enc[0]   = {5'b11110, cp[20:18]};
        enc[1]   = {2'b10, cp[17:12]};
        enc[2]   = {2'b10, cp[11:6]};
        enc[3]   = {2'b10, cp[5:0]};
        last_idx = 2'd3;
      end
    end
  end

  assign adv     = !valid_r || !out_stall;
  assign emit    = adv && !empty;
  assign at_last = (idx_r == last_idx);
  assign pop     = emit && at_last;

  always_comb begin
    valid_nxt = emit || (valid_r && out_stall);
    idx_nxt   = idx_r;
    if (emit) begin
      idx_nxt = at_last ? 2'd0 : idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      byte_r <= enc[idx_r];
      bval_r <= (head_job.kind != JOB_MARK);
      eor_r  <= at_last;
      eos_r  <= (head_job.kind == JOB_MARK);
      err_r  <= head_job.err;
    end
  end

  assign out_valid         = valid_r;
  assign out_byte          = byte_r;
  assign out_byte_valid    = bval_r;
  assign out_end_of_run    = eor_r;
  assign out_end_of_string = eos_r;
  assign out_error_code    = err_r;

endmodule

`default_nettype wire

### sv/json_string_unescape_utf8.sv
// ----------------------------------------------------------------------------
// json_string_unescape_utf8
// unescapes one quoted json string token into utf-8 text bytes
// ----------------------------------------------------------------------------
//  channel | ports                                   | handshake
//  input   | in_text_byte, in_last_byte              | in_valid / in_stall
//  result  | out_byte, out_byte_valid, out_end_of_*, | out_valid / out_stall
//          | out_error_code                          |
//
//  one input beat per cycle while the 4-entry job queue has room
//  one result beat per cycle while out_stall is low; a code point takes 1 to 4 result beats
//  so a \u escape yielding n bytes takes n result beats
//  first result beat is written to the job queue, then to the output register
//  synchronous active-low reset clears parser state, queue and output valid
// ----------------------------------------------------------------------------
`default_nettype none

module json_string_unescape_utf8 (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_text_byte,
  input  wire logic       in_last_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic            out_byte_valid,
  output logic            out_end_of_run,
  output logic            out_end_of_string,
  output logic [1:0]      out_error_code
);
  import jsu_pkg::*;

  job_t push_job;
  job_t head_job;
  logic push;
  logic pop;
  logic empty;
  logic full;
  logic accept;

  assign in_stall = full;
  assign accept   = in_valid && !full;

  jsu_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .text_byte (in_text_byte),
    .last_byte (in_last_byte),
    .job       (push_job),
    .job_push  (push)
  );

  jsu_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push && accept),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .empty    (empty),
    .full     (full)
  );

  jsu_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head_job          (head_job),
    .empty             (empty),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_byte          (out_byte),
    .out_byte_valid    (out_byte_valid),
    .out_end_of_run    (out_end_of_run),
    .out_end_of_string (out_end_of_string),
    .out_error_code    (out_error_code)
  );

endmodule

`default_nettype wire

### sv/jsu_checker.sv
// ----------------------------------------------------------------------------
// jsu_checker
// port-level checks for the json string unescaper
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic [7:0] in_text_byte,
  input wire logic       in_last_byte,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [7:0] out_byte,
  input wire logic       out_byte_valid,
  input wire logic       out_end_of_run,
  input wire logic       out_end_of_string,
  input wire logic [1:0] out_error_code
);
  import jsu_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_byte) && $stable(out_error_code))
    else $error("stalled result changed");

  a_marker: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_byte_valid |->
      out_byte == 8'd0 && out_end_of_run && out_end_of_string)
    else $error("end marker malformed");

  a_err_closes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error_code != ERR_NONE |-> out_end_of_string && !out_byte_valid)
    else $error("error without closing marker");

  a_data_open: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_byte_valid |-> !out_end_of_string && out_error_code == ERR_NONE)
    else $error("data beat flagged as string end");

endmodule

bind json_string_unescape_utf8 jsu_checker u_jsu_checker (.*);

`default_nettype wire

### tb/tb_json_string_unescape_utf8.sv
// ----------------------------------------------------------------------------
// tb_json_string_unescape_utf8
// drives quoted string tokens one byte per beat, with directed framing,
// escape and surrogate cases followed by random well-formed, broken and noisy
// tokens under random idling and a long output hold-off; a cycle-free model of
// the unescaper predicts every utf-8 beat and each result is checked in order
// ----------------------------------------------------------------------------

module tb_json_string_unescape_utf8;
  timeunit 1ns;
  timeprecision 1ps;

  import jsu_pkg::*;

  localparam int         IDLE_PCT        = 13;
  localparam int         HOLD_CYCLES     = 80;
  localparam int         WATCHDOG_CYCLES = 1000;
  localparam int         DRAIN_CYCLES    = 12;
  localparam int         REPORT_LIMIT    = 10;
  localparam int         RANDOM_ITEMS    = 60;
  localparam int         NOISE_ITEMS     = 30;

  localparam logic [7:0] ASC_A_UP = 8'h41;
  localparam logic [7:0] CTL_BS   = 8'h08;
  localparam logic [7:0] CTL_TAB  = 8'h09;
  localparam logic [7:0] CTL_LF   = 8'h0A;
  localparam logic [7:0] CTL_FF   = 8'h0C;
  localparam logic [7:0] CTL_CR   = 8'h0D;
  localparam logic [7:0] CONT     = 8'h80;
  localparam logic [7:0] LEAD2    = 8'hC0;
  localparam logic [7:0] LEAD3    = 8'hE0;
  localparam logic [7:0] LEAD4    = 8'hF0;

  localparam logic [7:0] SIMPLE_ESC [8] = '{CH_QUOTE, CH_BSLASH, CH_SLASH, CH_B,
                                             CH_F, CH_N, CH_R, CH_T};

  typedef struct packed {
    logic [7:0] data;
    logic       dv;
    logic       eor;
    logic       eos;
    err_t       err;
  } utf8_beat_t;

  logic       clk          = 1'b0;
  logic       rst_n        = 1'b0;
  logic       in_valid     = 1'b0;
  logic       in_stall;
  logic [7:0] in_text_byte = 8'h00;
  logic       in_last_byte = 1'b0;
  logic       out_valid;
  logic       out_stall    = 1'b0;
  logic [7:0] out_byte;
  logic       out_byte_valid;
  logic       out_end_of_run;
  logic       out_end_of_string;
  logic [1:0] out_error_code;

  // unescaper model state
  phase_t      parse_phase  = PH_OPEN;
  logic [15:0] hex_acc      = '0;
  logic [9:0]  pending_high = '0;
  logic [2:0]  hex_digits   = '0;
  logic        skip_to_close = 1'b0;
  int          beats_now;

  utf8_beat_t  utf8_due[$];
  logic [7:0]  tok[$];
  int          accepted_items = 0;
  int          mismatches     = 0;
  int          quiet_cycles   = 0;
  int          hold_left      = 0;
  logic        calm           = 1'b0;

  json_string_unescape_utf8 dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_text_byte      (in_text_byte),
    .in_last_byte      (in_last_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_byte          (out_byte),
    .out_byte_valid    (out_byte_valid),
    .out_end_of_run    (out_end_of_run),
    .out_end_of_string (out_end_of_string),
    .out_error_code    (out_error_code)
  );

  always #1 clk = ~clk;

  function automatic void restart_parse();
    parse_phase   = PH_OPEN;
    hex_acc       = '0;
    pending_high  = '0;
    hex_digits    = '0;
    skip_to_close = 1'b0;
  endfunction

  function automatic void push_beat(logic [7:0] data, logic dv, logic eos, err_t err);
    utf8_due.insert(utf8_due.size(), utf8_beat_t'{data, dv, 1'b0, eos, err});
    beats_now++;
  endfunction

  function automatic void raise_error(err_t err);
    push_beat(8'h00, 1'b0, 1'b1, err);
    restart_parse();
    skip_to_close = 1'b1;
  endfunction

  function automatic void push_utf8(logic [20:0] cp);
    if (cp < LIMIT_1B) begin
      push_beat(cp[7:0], 1'b1, 1'b0, ERR_NONE);
    end else if (cp < LIMIT_2B) begin
      push_beat(LEAD2 | {3'b0, cp[10:6]}, 1'b1, 1'b0, ERR_NONE);
      push_beat(CONT | {2'b0, cp[5:0]}, 1'b1, 1'b0, ERR_NONE);
    end else if (cp < LIMIT_3B) begin
      push_beat(LEAD3 | {4'b0, cp[15:12]}, 1'b1, 1'b0, ERR_NONE);
      push_beat(CONT | {2'b0, cp[11:6]}, 1'b1, 1'b0, ERR_NONE);
      push_beat(CONT | {2'b0, cp[5:0]}, 1'b1, 1'b0, ERR_NONE);
    end else begin
      push_beat(LEAD4 | {5'b0, cp[20:18]}, 1'b1, 1'b0, ERR_NONE);
      push_beat(CONT | {2'b0, cp[17:12]}, 1'b1, 1'b0, ERR_NONE);
      push_beat(CONT | {2'b0, cp[11:6]}, 1'b1, 1'b0, ERR_NONE);
      push_beat(CONT | {2'b0, cp[5:0]}, 1'b1, 1'b0, ERR_NONE);
    end
  endfunction

  function automatic logic [3:0] digit_value(logic [7:0] c);
    logic [7:0] v;
    if (c >= CH_0 && c <= CH_9) v = c - CH_0;
    else if (c >= CH_A_LO && c <= CH_F_LO) v = c - CH_A_LO + 8'd10;
    else v = c - ASC_A_UP + 8'd10;
    return v[3:0];
  endfunction

  function automatic logic take_digit(logic [7:0] c);
    hex_acc    = {hex_acc[11:0], digit_value(c)};
    hex_digits = hex_digits + 3'd1;
    return hex_digits >= 3'd4;
  endfunction

  function automatic void unescape_step(logic [7:0] c, logic last);
    logic [15:0] u;
    utf8_beat_t  tail;
    beats_now = 0;
    if (skip_to_close) begin
      if (last) restart_parse();
      return;
    end
    accepted_items++;
    if (parse_phase == PH_OPEN) begin
      if (last) push_beat(8'h00, 1'b0, 1'b1, ERR_NONE);
      else parse_phase = PH_BODY;
    end else if (last) begin
      push_beat(8'h00, 1'b0, 1'b1,
                (parse_phase inside {PH_WANT_BS, PH_WANT_U, PH_HEX2}) ? ERR_NO_LOW : ERR_NONE);
      restart_parse();
    end else begin
      case (parse_phase)
        PH_BODY: begin
          if (c == CH_BSLASH) parse_phase = PH_ESC;
          else push_beat(c, 1'b1, 1'b0, ERR_NONE);
        end
        PH_ESC: begin
          parse_phase = PH_BODY;
          case (c)
            CH_QUOTE, CH_BSLASH, CH_SLASH: push_beat(c, 1'b1, 1'b0, ERR_NONE);
            CH_B: push_beat(CTL_BS, 1'b1, 1'b0, ERR_NONE);
            CH_F: push_beat(CTL_FF, 1'b1, 1'b0, ERR_NONE);
            CH_N: push_beat(CTL_LF, 1'b1, 1'b0, ERR_NONE);
            CH_R: push_beat(CTL_CR, 1'b1, 1'b0, ERR_NONE);
            CH_T: push_beat(CTL_TAB, 1'b1, 1'b0, ERR_NONE);
            default: begin
              parse_phase = PH_HEX1;
              hex_acc     = '0;
              hex_digits  = '0;
            end
          endcase
        end
        PH_HEX1: begin
          if (take_digit(c)) begin
            u          = hex_acc;
            hex_acc    = '0;
            hex_digits = '0;
            if (u >= LOW_FIRST && u <= LOW_LAST) begin
              raise_error(ERR_LONE_LOW);
            end else if (u >= HIGH_FIRST && u <= HIGH_LAST) begin
              pending_high = u[9:0];
              parse_phase  = PH_WANT_BS;
            end else begin
              push_utf8({5'b0, u});
              parse_phase = PH_BODY;
            end
          end
        end
        PH_WANT_BS: begin
          if (c == CH_BSLASH) parse_phase = PH_WANT_U;
          else raise_error(ERR_NO_LOW);
        end
        PH_WANT_U: begin
          if (c == CH_U) begin
            parse_phase = PH_HEX2;
            hex_acc     = '0;
            hex_digits  = '0;
          end else begin
            raise_error(ERR_NO_LOW);
          end
        end
        PH_HEX2: begin
          if (take_digit(c)) begin
            u          = hex_acc;
            hex_acc    = '0;
            hex_digits = '0;
            if (u >= LOW_FIRST && u <= LOW_LAST) begin
              push_utf8(SUPP_BASE + {1'b0, pending_high, u[9:0]});
              pending_high = '0;
              parse_phase  = PH_BODY;
            end else begin
              raise_error(ERR_NO_LOW);
            end
          end
        end
        default: restart_parse();
      endcase
    end
    if (beats_now > 0) begin
      tail     = utf8_due[utf8_due.size() - 1];
      tail.eor = 1'b1;
      utf8_due[utf8_due.size() - 1] = tail;
    end
  endfunction

  function automatic void note_mismatch(string why, utf8_beat_t want, utf8_beat_t got);
    mismatches++;
    if (mismatches <= REPORT_LIMIT)
      $display("mismatch (%s) want byte %h dv %b run %b str %b err %0d", why,
               want.data, want.dv, want.eor, want.eos, want.err,
               " | got byte %h dv %b run %b str %b err %0d",
               got.data, got.dv, got.eor, got.eos, got.err);
  endfunction

  // result check first, then predict the beat accepted at this edge
  always @(posedge clk) begin : track_beats
    utf8_beat_t want;
    utf8_beat_t got;
    if (rst_n && out_valid && !out_stall) begin
      got = utf8_beat_t'{out_byte, out_byte_valid, out_end_of_run, out_end_of_string,
                         err_t'(out_error_code)};
      if (utf8_due.size() == 0) begin
        note_mismatch("no beat due", '0, got);
      end else begin
        want = utf8_due.pop_front();
        if (got !== want) note_mismatch("field", want, got);
      end
    end
    if (rst_n && in_valid && !in_stall) unescape_step(in_text_byte, in_last_byte);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  task automatic send_beat(logic [7:0] b, logic last);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_text_byte <= b;
    in_last_byte <= last;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic send_token(logic [7:0] open_b, logic [7:0] close_b);
    send_beat(open_b, 1'b0);
    foreach (tok[i]) send_beat(tok[i], 1'b0);
    send_beat(close_b, 1'b1);
    tok.delete();
  endtask

  // valid drops first so no accepted beat is offered again while waiting
  task automatic set_pace(logic quiet, int hold);
    in_valid <= 1'b0;
    @(posedge clk);
    calm      = quiet;
    hold_left = hold;
    @(negedge clk);
  endtask

  function automatic void add_tok(logic [7:0] b);
    tok.insert(tok.size(), b);
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] n);
    if (n < 4'd10) return CH_0 + {4'd0, n};
    return ($urandom_range(0, 1) ? CH_A_LO : ASC_A_UP) + {4'd0, n} - 8'd10;
  endfunction

  function automatic void put_unit(logic [15:0] u, logic [7:0] letter, logic sloppy);
    add_tok(CH_BSLASH);
    add_tok(letter);
    for (int i = 3; i >= 0; i--) begin
      if (sloppy && $urandom_range(0, 99) < 3) add_tok(8'($urandom));
      else add_tok(hex_char(u[i*4 +: 4]));
    end
  endfunction

  function automatic logic [15:0] random_bmp();
    logic [15:0] u;
    case ($urandom_range(0, 2))
      0:       u = 16'($urandom_range(0, 16'h7F));
      1:       u = 16'($urandom_range(16'h80, 16'h7FF));
      default: u = 16'($urandom_range(16'h800, 16'hFFFF));
    endcase
    if (u >= HIGH_FIRST && u <= LOW_LAST) u ^= 16'h4000;
    return u;
  endfunction

  function automatic logic [15:0] random_high();
    return 16'($urandom_range(HIGH_FIRST, HIGH_LAST));
  endfunction

  function automatic logic [15:0] random_low();
    return 16'($urandom_range(LOW_FIRST, LOW_LAST));
  endfunction

  function automatic logic [7:0] unit_letter();
    logic [7:0] b;
    if ($urandom_range(0, 7) != 0) return CH_U;
    b = 8'($urandom);
    if (b inside {CH_QUOTE, CH_BSLASH, CH_SLASH, CH_B, CH_F, CH_N, CH_R, CH_T}) b = CH_U;
    return b;
  endfunction

  function automatic void build_random_token(int parts);
    int         pick;
    logic [7:0] b;
    for (int p = 0; p < parts; p++) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        b = 8'($urandom);
        if (b == CH_BSLASH) add_tok(CH_BSLASH);
        add_tok(b);
      end else if (pick < 55) begin
        add_tok(CH_BSLASH);
        add_tok(SIMPLE_ESC[$urandom_range(0, 7)]);
      end else if (pick < 75) begin
        put_unit(random_bmp(), unit_letter(), 1'b1);
      end else if (pick < 87) begin
        put_unit(random_high(), unit_letter(), 1'b1);
        put_unit(random_low(), CH_U, 1'b1);
      end else if (pick < 90) begin
        put_unit(random_low(), unit_letter(), 1'b0);
      end else if (pick < 95) begin
        // high half followed by something that is not a low half
        put_unit(random_high(), unit_letter(), 1'b0);
        case ($urandom_range(0, 2))
          0: begin
            do b = 8'($urandom); while (b == CH_BSLASH);
            add_tok(b);
          end
          1: begin
            do b = 8'($urandom); while (b == CH_U);
            add_tok(CH_BSLASH);
            add_tok(b);
          end
          default: put_unit($urandom_range(0, 1) ? random_high() : random_bmp(), CH_U, 1'b0);
        endcase
      end else begin
        // escape left open when the closing quote arrives
        case ($urandom_range(0, 4))
          0: add_tok(CH_BSLASH);
          1: begin
            add_tok(CH_BSLASH);
            add_tok(unit_letter());
            repeat ($urandom_range(0, 3)) add_tok(hex_char(4'($urandom)));
          end
          2: put_unit(random_high(), CH_U, 1'b0);
          3: begin
            put_unit(random_high(), CH_U, 1'b0);
            add_tok(CH_BSLASH);
          end
          default: begin
            put_unit(random_high(), CH_U, 1'b0);
            add_tok(CH_BSLASH);
            add_tok(CH_U);
            repeat ($urandom_range(0, 3)) add_tok(hex_char(4'($urandom)));
          end
        endcase
        return;
      end
    end
  endfunction

  function automatic int random_parts();
    if ($urandom_range(0, 7) == 0) return $urandom_range(7, 20);
    return $urandom_range(1, 6);
  endfunction

  task automatic test_framing();
    send_beat(8'hA5, 1'b1);
    send_token(8'h00, 8'hFF);
    tok = '{8'h00, 8'hFF, CH_QUOTE, CH_BSLASH, CH_N};
    send_token(8'hFF, 8'h00);
  endtask

  task automatic test_unicode_widths();
    put_unit(16'h07FF, CH_A_LO, 1'b0);
    put_unit(16'hFFFF, CH_U, 1'b0);
    put_unit(16'hDBFF, CH_U, 1'b0);
    put_unit(16'hDFFF, CH_U, 1'b0);
    send_token(8'h22, 8'h22);
  endtask

  task automatic test_surrogate_faults();
    put_unit(LOW_FIRST, CH_U, 1'b0);
    add_tok(CH_U);
    send_token(8'h22, 8'h22);
    put_unit(HIGH_FIRST, CH_U, 1'b0);
    send_token(8'h22, 8'h22);
    add_tok(CH_BSLASH);
    send_token(8'h22, 8'h22);
  endtask

  task automatic test_back_to_back();
    set_pace(1'b1, 0);
    repeat (3) begin
      build_random_token(random_parts());
      send_token(8'($urandom), 8'($urandom));
    end
    set_pace(1'b0, 0);
  endtask

  task automatic test_stalled_output();
    set_pace(1'b1, HOLD_CYCLES);
    repeat (2) begin
      repeat (3) put_unit(16'($urandom_range(16'h800, 16'hD7FF)), CH_U, 1'b0);
      send_token(8'($urandom), 8'($urandom));
    end
    set_pace(1'b0, 0);
  endtask

  task automatic test_random_tokens();
    int target;
    target = accepted_items + RANDOM_ITEMS;
    while (accepted_items < target) begin
      build_random_token(random_parts());
      send_token(8'($urandom), 8'($urandom));
    end
  endtask

  task automatic test_line_noise();
    repeat (NOISE_ITEMS) send_beat(8'($urandom), $urandom_range(0, 9) == 0);
    send_beat(8'($urandom), 1'b1);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_framing();
    test_unicode_widths();
    test_surrogate_faults();
    test_back_to_back();
    test_stalled_output();
    test_random_tokens();
    test_line_noise();
    in_valid <= 1'b0;
    while (utf8_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### files.f
sv/jsu_pkg.sv
sv/jsu_front.sv
sv/jsu_fifo.sv
sv/jsu_back.sv
sv/json_string_unescape_utf8.sv
sv/jsu_checker.sv
tb/tb_json_string_unescape_utf8.sv
